// ----- src/software_breakpoint_table_top_defines.svh -----
// ----------------------------------------------------------------------------
// Breakpoint table assertion macros
// Shared assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SOFTWARE_BREAKPOINT_TABLE_TOP_DEFINES_SVH
`define SOFTWARE_BREAKPOINT_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on rising clk, ignored while rst_n is low
`define SBT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every rising clk, reset included
`define SBT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBT_ASSERT(name, prop, msg)
`define SBT_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- src/sbt_pkg.sv -----
// ----------------------------------------------------------------------------
// Breakpoint table package
// Sizes, command and status codes, and the probe word passed along the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbt_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int SLOT_LIMIT    = 32;
  localparam int USED_SLOTS    = (TABLE_ENTRIES > SLOT_LIMIT) ? SLOT_LIMIT : TABLE_ENTRIES;
  localparam int SLOT_W        = 5;
  localparam int ADDR_W        = 32;
  localparam int WORD_W        = 32;

  localparam logic [WORD_W-1:0] BREAK_WORD = 32'h002a_0000;
  localparam logic [WORD_W-1:0] BREAK_MASK = 32'hffff_8000;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_SCAN = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_WINDOW   = 3'd1,
    ST_IS_BREAK = 3'd2,
    ST_FULL     = 3'd3,
    ST_NO_MATCH = 3'd4
  } status_t;

  // Travels one cell per cycle. On a hit, num carries the slot; on a delete
  // hit addr/word are swapped for the entry's; on a scan hit word is swapped.
  typedef struct packed {
    logic              valid;
    cmd_t              cmd;
    logic              blocked;     // add refused before reaching the cells
    status_t           pre_status;
    logic              hit;
    logic [SLOT_W-1:0] num;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
  } probe_t;

endpackage

// ----- src/sbt_cell.sv -----
// ----------------------------------------------------------------------------
// Breakpoint table cell
// One table slot plus one probe stage; acts on the probe and hands it on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "software_breakpoint_table_top_defines.svh"

module sbt_cell
  import sbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SLOT_W-1:0] cell_idx,
  input  probe_t            probe_in,
  output probe_t            probe_out
);

  logic              live_r, live_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [WORD_W-1:0] word_r;
  probe_t            probe_r, probe_nxt;
  logic              add_hit, del_hit, scan_hit;

  assign add_hit  = probe_in.valid && (probe_in.cmd == CMD_ADD) && !probe_in.blocked &&
                    !probe_in.hit && !live_r;
  assign del_hit  = probe_in.valid && (probe_in.cmd == CMD_DEL) &&
                    (probe_in.num == cell_idx) && live_r;
  assign scan_hit = probe_in.valid && (probe_in.cmd == CMD_SCAN) && !probe_in.hit &&
                    live_r && (addr_r == probe_in.addr);

  always_comb begin
    live_nxt  = live_r;
    probe_nxt = probe_in;
    if (add_hit) begin
      live_nxt      = 1'b1;
      probe_nxt.hit = 1'b1;
      probe_nxt.num = cell_idx;
    end
    if (del_hit) begin
      live_nxt       = 1'b0;
      probe_nxt.hit  = 1'b1;
      probe_nxt.addr = addr_r;
      probe_nxt.word = word_r;
    end
    if (scan_hit) begin
      probe_nxt.hit  = 1'b1;
      probe_nxt.num  = cell_idx;
      probe_nxt.word = word_r;
    end
  end

  // valid and live are reset; payload is not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r        <= 1'b0;
      probe_r.valid <= 1'b0;
    end else begin
      live_r        <= live_nxt;
      probe_r.valid <= probe_nxt.valid;
    end
    probe_r.cmd        <= probe_nxt.cmd;
    probe_r.blocked    <= probe_nxt.blocked;
    probe_r.pre_status <= probe_nxt.pre_status;
    probe_r.hit        <= probe_nxt.hit;
    probe_r.num        <= probe_nxt.num;
    probe_r.addr       <= probe_nxt.addr;
    probe_r.word       <= probe_nxt.word;
    if (add_hit) begin
      addr_r <= probe_in.addr;
      word_r <= probe_in.word;
    end
  end

  assign probe_out = probe_r;

  `SBT_ASSERT(a_live_rise_by_add, $rose(live_r) |-> $past(add_hit), "slot live without an add")
  `SBT_ASSERT(a_del_frees, del_hit |=> !live_r, "deleted slot still live")
  `SBT_ASSERT(a_one_hit_kind, $onehot0({add_hit, del_hit, scan_hit}), "two actions at once")

endmodule

// ----- src/software_breakpoint_table_top.sv -----
// ----------------------------------------------------------------------------
// Software breakpoint table
// Add, delete and scan of breakpoint slots over a chain of table cells.
// ----------------------------------------------------------------------------
// The table is a row of USED_SLOTS cells (32), one slot each. An accepted word
// is turned into a probe that walks down the row one cell per cycle, so every
// command (add, delete, scan) gives its result word once the probe has passed
// the register of every cell in the chain. One command is in the chain at a time;
// in_tready returns when busy clears after the probe leaves the last cell and the
// skid stage is empty, so a new command can be taken while a finished result
// still sits unread in the output register (a second result is held in a
// one-word skid stage).
// The address window check and the break-instruction check happen when the
// word is accepted; a refused add still walks the chain but changes nothing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "software_breakpoint_table_top_defines.svh"

module software_breakpoint_table_top
  import sbt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready,
  // commands
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] cmd, [33:2] address, [65:34] current_instruction, [70:66] slot_number
  input  logic [71:0]  in_tdata,
  // results
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [7:3] slot, [8] write_request, [40:9] write_address,
  // [72:41] write_word, [104:73] saved_instruction
  output logic [111:0] out_tdata
);

  localparam logic [2:0] REG_BASE_ADDR = 3'd0;
  localparam logic [2:0] REG_SIZE_ADDR = 3'd4;

  logic [ADDR_W-1:0] mem_base_r, mem_size_r;
  logic              cfg_wr;

  logic              busy_r, busy_nxt;
  logic              out_v_r, out_v_nxt;
  logic [111:0]      out_d_r, out_d_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [111:0]      pend_d_r, pend_d_nxt;

  logic              in_fire, out_fire;
  cmd_t              in_cmd;
  logic [ADDR_W-1:0] in_addr;
  logic [WORD_W-1:0] in_inst;
  logic [SLOT_W-1:0] in_num;
  logic [ADDR_W-1:0] win_off;

  probe_t            launch_p;
  probe_t            chain_w [USED_SLOTS+1];
  probe_t            last_p;
  logic [111:0]      res_word;

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_base_r <= 32'h8000_0000;
      mem_size_r <= 32'h0800_0000;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) mem_size_r <= cfg_pwdata;
      else              mem_base_r <= cfg_pwdata;
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_BASE_ADDR: cfg_prdata = mem_base_r;
      REG_SIZE_ADDR: cfg_prdata = mem_size_r;
      default:       cfg_prdata = '0;
    endcase
  end

  // ---------------- launch ----------------
  assign in_tready = !busy_r && !pend_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tdata[1:0]);
  assign in_addr   = in_tdata[33:2];
  assign in_inst   = in_tdata[65:34];
  assign in_num    = in_tdata[70:66];
  assign win_off   = in_addr - mem_base_r;

  always_comb begin
    launch_p.valid      = in_fire;
    launch_p.cmd        = in_cmd;
    launch_p.blocked    = 1'b0;
    launch_p.pre_status = ST_OK;
    launch_p.hit        = 1'b0;
    launch_p.num        = in_num;
    launch_p.addr       = in_addr;
    launch_p.word       = in_inst;
    if (win_off >= mem_size_r) begin
      launch_p.blocked    = 1'b1;
      launch_p.pre_status = ST_WINDOW;
    end else if ((in_inst & BREAK_MASK) == BREAK_WORD) begin
      launch_p.blocked    = 1'b1;
      launch_p.pre_status = ST_IS_BREAK;
    end
  end

  assign chain_w[0] = launch_p;

  for (genvar i = 0; i < USED_SLOTS; i++) begin : g_cell
    sbt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (SLOT_W'(i)),
      .probe_in  (chain_w[i]),
      .probe_out (chain_w[i+1])
    );
  end

  assign last_p = chain_w[USED_SLOTS];

  // ---------------- result build ----------------
  always_comb begin
    status_t           st;
    logic [SLOT_W-1:0] sl;
    logic              wreq;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wword;
    logic [WORD_W-1:0] saved;
    st    = ST_NO_MATCH;
    sl    = '0;
    wreq  = 1'b0;
    waddr = '0;
    wword = '0;
    saved = '0;
    case (last_p.cmd)
      CMD_ADD: begin
        if (last_p.blocked) begin
          st = last_p.pre_status;
        end else if (last_p.hit) begin
          st    = ST_OK;
          sl    = last_p.num;
          wreq  = 1'b1;
          waddr = last_p.addr;
          wword = BREAK_WORD;
        end else begin
          st = ST_FULL;
        end
      end
      CMD_DEL: begin
        if (last_p.hit) begin
          st    = ST_OK;
          sl    = last_p.num;
          wreq  = 1'b1;
          waddr = last_p.addr;
          wword = last_p.word;
        end
      end
      CMD_SCAN: begin
        if (last_p.hit) begin
          st    = ST_OK;
          sl    = last_p.num;
          saved = last_p.word;
        end
      end
      default: st = ST_NO_MATCH;
    endcase
    res_word = {7'd0, saved, wword, waddr, wreq, sl, st};
  end

  // ---------------- output register + skid ----------------
  assign out_fire = out_v_r && out_tready;

  always_comb begin
    busy_nxt   = busy_r;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    pend_v_nxt = pend_v_r;
    pend_d_nxt = pend_d_r;
    if (in_fire)      busy_nxt = 1'b1;
    if (last_p.valid) busy_nxt = 1'b0;
    if (!out_v_r || out_fire) begin
      if (last_p.valid) begin
        out_v_nxt = 1'b1;
        out_d_nxt = res_word;
      end else if (pend_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = pend_d_r;
        pend_v_nxt = 1'b0;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (last_p.valid) begin
      pend_v_nxt = 1'b1;
      pend_d_nxt = res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    pend_d_r <= pend_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  `SBT_ASSERT(a_accept_sets_busy, in_fire |=> busy_r, "busy not set after accept")
  `SBT_ASSERT(a_result_only_when_busy, last_p.valid |-> busy_r, "result with nothing in flight")
  `SBT_ASSERT(a_skid_behind_out, pend_v_r |-> out_v_r, "skid full while output empty")
  `SBT_ASSERT(a_no_launch_in_flight, busy_r |-> !chain_w[0].valid, "launch into busy chain")

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// Breakpoint table testbench
// Drives add, delete and scan words through the stream ports and sets the
// memory window over the APB port. A shadow copy of the slot table predicts
// each result word, and every result is checked field by field against the
// oldest prediction. Both stream sides idle at random, and one phase holds
// the result side off long enough to back the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sbt_pkg::*;

  localparam int          CYCLE_LIMIT     = 200000;
  localparam int          DRAIN_CYCLES    = USED_SLOTS + 8;
  localparam logic [2:0]  REG_MEMORY_BASE = 3'd0;
  localparam logic [2:0]  REG_MEMORY_SIZE = 3'd4;

  typedef struct {
    status_t     status;
    logic [4:0]  slot;
    logic        wr_req;
    logic [31:0] wr_addr;
    logic [31:0] wr_word;
    logic [31:0] saved_word;
  } bp_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // [1:0] cmd, [33:2] address, [65:34] current_instruction, [70:66] slot_number
  logic [71:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [2:0] status, [7:3] slot, [8] write_request, [40:9] write_address,
  // [72:41] write_word, [104:73] saved_instruction
  logic [111:0] out_tdata;

  // shadow of the slot table and the window registers
  bit           bp_live [USED_SLOTS];
  logic [31:0]  bp_addr [USED_SLOTS];
  logic [31:0]  bp_orig [USED_SLOTS];
  logic [31:0]  win_base;
  logic [31:0]  win_size;

  bp_result_t   pending_bp_results [$];
  bp_result_t   want_res;
  int           err_count = 0;
  int unsigned  cycle_count;
  bit           pace_on = 1'b1;
  int           stall_left = 0;
  int           rx_hold = 0;

  software_breakpoint_table_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bp_result_t predict_breakpoint_op(cmd_t op, logic [31:0] addr,
                                                       logic [31:0] inst, logic [4:0] num);
    bp_result_t  r;
    logic [31:0] offset;
    r.status     = ST_NO_MATCH;
    r.slot       = '0;
    r.wr_req     = 1'b0;
    r.wr_addr    = '0;
    r.wr_word    = '0;
    r.saved_word = '0;
    offset = addr - win_base;
    case (op)
      CMD_ADD: begin
        if (offset >= win_size) begin
          r.status = ST_WINDOW;
        end else if ((inst & BREAK_MASK) == BREAK_WORD) begin
          r.status = ST_IS_BREAK;
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < USED_SLOTS; i++) begin
            if (!bp_live[i]) begin
              bp_live[i] = 1'b1;
              bp_addr[i] = addr;
              bp_orig[i] = inst;
              r.status   = ST_OK;
              r.slot     = i[4:0];
              r.wr_req   = 1'b1;
              r.wr_addr  = addr;
              r.wr_word  = BREAK_WORD;
              break;
            end
          end
        end
      end
      CMD_DEL: begin
        if (int'(num) < USED_SLOTS && bp_live[num]) begin
          bp_live[num] = 1'b0;
          r.status  = ST_OK;
          r.slot    = num;
          r.wr_req  = 1'b1;
          r.wr_addr = bp_addr[num];
          r.wr_word = bp_orig[num];
        end
      end
      CMD_SCAN: begin
        for (int i = 0; i < USED_SLOTS; i++) begin
          if (bp_live[i] && bp_addr[i] == addr) begin
            r.status     = ST_OK;
            r.slot       = i[4:0];
            r.saved_word = bp_orig[i];
            break;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_live_slot();
    int cand [$];
    for (int i = 0; i < USED_SLOTS; i++)
      if (bp_live[i]) cand.push_back(i);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < USED_SLOTS; i++)
      if (bp_live[i]) n++;
    return n;
  endfunction

  function automatic logic [31:0] window_addr();
    if (win_size == 0) return win_base;
    return win_base + ($urandom % win_size);
  endfunction

  function automatic logic [31:0] boundary_addr();
    case ($urandom_range(0, 3))
      0:       return win_base;
      1:       return win_base + win_size - 1;
      2:       return win_base - 1;
      default: return win_base + win_size;
    endcase
  endfunction

  function automatic logic [31:0] plain_inst();
    logic [31:0] v;
    v = $urandom;
    if ((v & BREAK_MASK) == BREAK_WORD) v[31] = ~v[31];
    return v;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_cmd(input cmd_t op, input logic [31:0] addr,
                          input logic [31:0] inst, input logic [4:0] num);
    int gap;
    gap = pace_on ? $urandom_range(0, 4) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, num, inst, addr, op};
    do @(posedge clk); while (!in_tready);
    pending_bp_results.push_back(predict_breakpoint_op(op, addr, inst, num));
  endtask

  task automatic send_random_op(input int add_pct);
    int          roll;
    int          s;
    cmd_t        op;
    logic [31:0] a;
    logic [31:0] inst;
    logic [4:0]  num;
    roll = $urandom_range(0, 99);
    if (roll < add_pct)                              op = CMD_ADD;
    else if (roll < add_pct + (100 - add_pct) * 2 / 5) op = CMD_DEL;
    else if (roll < 97)                              op = CMD_SCAN;
    else                                             op = CMD_NONE;
    a    = $urandom;
    inst = $urandom;
    num  = 5'($urandom);
    s    = pick_live_slot();
    case (op)
      CMD_ADD: begin
        roll = $urandom_range(0, 9);
        if (roll < 7)                 a = window_addr();
        else if (roll == 7)           a = boundary_addr();
        else if (roll == 8 && s >= 0) a = bp_addr[s];   // same address twice
        if ($urandom_range(0, 6) == 0) inst = BREAK_WORD | (inst & ~BREAK_MASK);
      end
      CMD_DEL: begin
        if (s >= 0 && $urandom_range(0, 5) != 0) num = s[4:0];
      end
      CMD_SCAN: begin
        roll = $urandom_range(0, 9);
        if (roll < 6 && s >= 0) a = bp_addr[s];
        else if (roll < 8)      a = window_addr();
      end
      default: ;
    endcase
    send_cmd(op, a, inst, num);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (addr)
      REG_MEMORY_BASE: win_base = value;
      REG_MEMORY_SIZE: win_size = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // drop the input word, let every result come back, then let the chain empty
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_bp_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checker

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      stall_left = pace_on ? $urandom_range(0, 4) : 0;
      if (pending_bp_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_tdata);
        err_count++;
      end else begin
        want_res = pending_bp_results.pop_front();
        compare_field("status", 32'(want_res.status), 32'(out_tdata[2:0]));
        compare_field("slot", 32'(want_res.slot), 32'(out_tdata[7:3]));
        compare_field("write_request", 32'(want_res.wr_req), 32'(out_tdata[8]));
        compare_field("write_address", want_res.wr_addr, out_tdata[40:9]);
        compare_field("write_word", want_res.wr_word, out_tdata[72:41]);
        compare_field("saved_instruction", want_res.saved_word, out_tdata[104:73]);
      end
    end
  end

  // result side: long hold first, then the per-word stall
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_directed_ops();
    send_cmd(CMD_SCAN, 32'h8000_0000, 32'h0, 5'd0);          // empty table
    send_cmd(CMD_ADD,  32'h8000_0000, 32'h0000_0013, 5'd0);  // lowest window address
    send_cmd(CMD_ADD,  32'h87ff_fffc, 32'hffff_ffff, 5'd0);
    send_cmd(CMD_ADD,  32'h87ff_ffff, 32'h002a_7fff, 5'd0);  // already a break
    send_cmd(CMD_ADD,  32'h7fff_ffff, 32'h0, 5'd0);          // just below window
    send_cmd(CMD_ADD,  32'h8800_0000, 32'h0, 5'd0);          // just above window
    send_cmd(CMD_ADD,  32'hffff_ffff, BREAK_WORD, 5'd0);     // window wins over break
    send_cmd(CMD_ADD,  32'h0000_0000, 32'h0, 5'd0);
    send_cmd(CMD_ADD,  32'h8000_0000, 32'h1234_5678, 5'd0);  // same address again
    send_cmd(CMD_SCAN, 32'h8000_0000, 32'h0, 5'd0);          // lowest slot wins
    send_cmd(CMD_SCAN, 32'h87ff_fffc, 32'h0, 5'd0);
    send_cmd(CMD_DEL,  32'h0, 32'h0, 5'd0);
    send_cmd(CMD_SCAN, 32'h8000_0000, 32'h0, 5'd0);          // now the duplicate
    send_cmd(CMD_DEL,  32'h0, 32'h0, 5'd0);                  // free slot
    send_cmd(CMD_DEL,  32'h0, 32'h0, 5'd31);
    send_cmd(CMD_NONE, 32'hffff_ffff, 32'hffff_ffff, 5'd31); // unused command
    send_cmd(CMD_ADD,  32'h8000_1000, 32'h002b_0000, 5'd0);  // refills slot 0
    send_cmd(CMD_ADD,  32'h8000_2000, 32'h002a_8000, 5'd0);  // outside the mask match
    send_cmd(CMD_SCAN, 32'h1234_5678, 32'h0, 5'd0);
    send_cmd(CMD_DEL,  32'h0, 32'h0, 5'd1);
    send_cmd(CMD_DEL,  32'h0, 32'h0, 5'd2);
    send_cmd(CMD_DEL,  32'h0, 32'h0, 5'd0);
    send_cmd(CMD_DEL,  32'h0, 32'h0, 5'd3);
    wait_idle();
  endtask

  task automatic test_table_full();
    int s;
    while (live_count() < USED_SLOTS)
      send_cmd(CMD_ADD, window_addr(), plain_inst(), 5'd0);
    send_cmd(CMD_ADD, window_addr(), plain_inst(), 5'd0);               // full
    send_cmd(CMD_ADD, window_addr(), BREAK_WORD | 32'h7fff, 5'd0);     // break beats full
    send_cmd(CMD_ADD, win_base - 1, plain_inst(), 5'd0);               // window beats full
    s = pick_live_slot();
    send_cmd(CMD_DEL, 32'h0, 32'h0, s[4:0]);
    send_cmd(CMD_ADD, window_addr(), plain_inst(), 5'd0);               // takes the freed slot
    s = pick_live_slot();
    send_cmd(CMD_SCAN, bp_addr[s], 32'h0, 5'd0);
    s = pick_live_slot();
    while (s >= 0) begin
      send_cmd(CMD_DEL, $urandom, $urandom, s[4:0]);
      s = pick_live_slot();
    end
    wait_idle();
  endtask

  task automatic test_random_mix();
    repeat (100) send_random_op(55);
    wait_idle();
    pace_on = 1'b0;
    repeat (50) send_random_op(40);
    wait_idle();
    pace_on = 1'b1;
  endtask

  task automatic test_window_settings();
    logic [31:0] base;
    logic [31:0] size;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0:       begin base = 32'h0000_0000; size = 32'h0000_0000; end
        1:       begin base = 32'hffff_ffff; size = 32'hffff_ffff; end
        2:       begin base = 32'h0000_0000; size = 32'hffff_ffff; end
        3:       begin base = 32'hfff0_0000; size = 32'h0020_0000; end  // wraps past zero
        4:       begin base = 32'h0000_1000; size = 32'h0000_0001; end
        default: begin base = 32'h8000_0000; size = 32'h0800_0000; end
      endcase
      write_reg(REG_MEMORY_BASE, base);
      write_reg(REG_MEMORY_SIZE, size);
      send_cmd(CMD_ADD, base - 1, plain_inst(), 5'd0);
      send_cmd(CMD_ADD, base, plain_inst(), 5'd0);
      send_cmd(CMD_ADD, base + size - 1, plain_inst(), 5'd0);
      send_cmd(CMD_ADD, base + size, plain_inst(), 5'd0);
      repeat (20) send_random_op(45);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    @(posedge clk);
    rx_hold = 400;
    pace_on = 1'b0;
    repeat (10) send_random_op(50);
    wait_idle();
    pace_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    win_base = 32'h8000_0000;
    win_size = 32'h0800_0000;
    for (int i = 0; i < USED_SLOTS; i++) begin
      bp_live[i] = 1'b0;
      bp_addr[i] = '0;
      bp_orig[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_table_full();
    test_random_mix();
    test_window_settings();
    test_backpressure();
    wait_idle();
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, pending_bp_results.size());
    $display("FAILURE");
    $finish;
  end

endmodule
